// ----- hw/rtl/compacting_keyed_table_macros.svh -----
// Assertion macros used by the checker file.
`ifndef COMPACTING_KEYED_TABLE_MACROS_SVH
`define COMPACTING_KEYED_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CKT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ckt_pkg.sv -----
package ckt_pkg;

    localparam int CKT_CAPACITY  = 64;
    localparam int CKT_KEY_BITS  = 16;
    localparam int CKT_DATA_BITS = 32;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT
    } t_state;

endpackage

// ----- hw/rtl/compacting_keyed_table.sv -----
// Channel   Direction  Transfer when    Ports
// request   in         start && !busy   i_req_type, i_key, i_entry_data
// result    out        o_done           o_status, o_index, o_found_data, o_entry_count
//
// A search reads one entry per cycle from the key and data memories, so insert and
// lookup keep busy high until the search hits or runs past the last entry.
// A remove then moves each entry above the removed one down, one entry per cycle;
// an unused request type answers in the next cycle.
// The synchronous reset empties the table; the memories themselves are not cleared.
// The result appears for one cycle as busy falls, and the receiver cannot stall it.
module compacting_keyed_table
    import ckt_pkg::*;
#(
    parameter int CAPACITY  = CKT_CAPACITY,
    parameter int KEY_BITS  = CKT_KEY_BITS,
    parameter int DATA_BITS = CKT_DATA_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_entry_data,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_index,
    output logic [DATA_W-1:0]   o_found_data,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0]  key_mem  [CAPACITY];
    logic [DATA_BITS-1:0] data_mem [CAPACITY];

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_pidx, n_pidx;
    logic [AW-1:0]        r_wa, n_wa;
    logic [REQ_W-1:0]     r_req, n_req;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [DATA_BITS-1:0] r_data, n_data;
    logic                 r_done, n_done;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [INDEX_W-1:0]   r_index, n_index;
    logic [DATA_W-1:0]    r_found, n_found;
    logic [KEY_BITS-1:0]  r_rd_key;
    logic [DATA_BITS-1:0] r_rd_data;

    logic                 mem_re;
    logic [AW-1:0]        mem_ra;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [KEY_BITS-1:0]  mem_wkey;
    logic [DATA_BITS-1:0] mem_wdata;
    logic                 issue;
    logic                 hit;

    assign issue = (r_ptr < r_count);
    assign hit   = r_pend && (r_rd_key == r_key);

    // Reads and writes never meet at one address in the same cycle: a shift writes the
    // entry below the one it reads, and an insert ends the request.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[mem_wa]  <= mem_wkey;
            data_mem[mem_wa] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_key  <= key_mem[mem_ra];
            r_rd_data <= data_mem[mem_ra];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_wa      = r_wa;
        n_req     = r_req;
        n_key     = r_key;
        n_data    = r_data;
        n_done    = 1'b0;
        n_status  = r_status;
        n_index   = r_index;
        n_found   = r_found;
        mem_re    = 1'b0;
        mem_ra    = r_ptr[AW-1:0];
        mem_we    = 1'b0;
        mem_wa    = r_wa;
        mem_wkey  = r_rd_key;
        mem_wdata = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req_type;
                    n_key  = KEY_BITS'(i_key);
                    n_data = DATA_BITS'(i_entry_data);
                    n_ptr  = '0;
                    n_pend = 1'b0;
                    if (i_req_type == REQ_INSERT || i_req_type == REQ_REMOVE ||
                        i_req_type == REQ_LOOKUP) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ST_DONE;
                        n_index  = '0;
                        n_found  = '0;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    if (r_req == REQ_REMOVE) begin
                        n_state = S_SHIFT;
                        n_ptr   = CW'(r_pidx) + CW'(1);
                        n_pend  = 1'b0;
                    end else begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_index  = INDEX_W'(r_pidx);
                        if (r_req == REQ_LOOKUP) begin
                            n_status = ST_DONE;
                            n_found  = DATA_W'(r_rd_data);
                        end else begin
                            n_status = ST_DUPLICATE;
                            n_found  = '0;
                        end
                    end
                end else if (!issue) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_index = '0;
                    n_found = '0;
                    if (r_req == REQ_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wa    = r_count[AW-1:0];
                            mem_wkey  = r_key;
                            mem_wdata = r_data;
                            n_count   = r_count + CW'(1);
                            n_status  = ST_DONE;
                            n_index   = INDEX_W'(r_count);
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (issue) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_wa   = AW'(r_ptr - CW'(1));
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_state  = S_IDLE;
                    n_pend   = 1'b0;
                    n_count  = r_count - CW'(1);
                    n_done   = 1'b1;
                    n_status = ST_DONE;
                    n_index  = INDEX_W'(r_pidx);
                    n_found  = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_pidx   <= n_pidx;
        r_wa     <= n_wa;
        r_req    <= n_req;
        r_key    <= n_key;
        r_data   <= n_data;
        r_status <= n_status;
        r_index  <= n_index;
        r_found  <= n_found;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_index       = r_index;
    assign o_found_data  = r_found;
    assign o_entry_count = COUNT_W'(r_count);

endmodule

// ----- hw/rtl/ckt_checker.sv -----
`include "compacting_keyed_table_macros.svh"

module ckt_checker
    import ckt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [INDEX_W-1:0]  o_index,
    input logic [DATA_W-1:0]   o_found_data
);

    `CKT_ASSERT_NXT(a_accept_answers, i_clk, i_rst_n, start && !busy, busy || o_done, "Accepted request neither started nor answered.")
    `CKT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "Result strobe while the table is busy.")
    `CKT_ASSERT_IMP(a_busy_ends_done, i_clk, i_rst_n, $fell(busy), o_done, "Request ended without a result transfer.")
    `CKT_ASSERT_IMP(a_miss_clean, i_clk, i_rst_n, o_done && (o_status == ST_NOT_FOUND || o_status == ST_FULL), (o_index == '0) && (o_found_data == '0), "Failed request reports an index or data.")

endmodule

bind compacting_keyed_table ckt_checker u_ckt_checker (.*);
